/* sv/ccs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types and constants of the cocktail shaker sorter unit.
// ----------------------------------------------------------------------------
package ccs_pkg;

	localparam int unsigned DATA_W = 32;

	// One element travelling along, or held in, the cell chain.
	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] value;
	} link_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SETTLE,
		ST_DRAIN
	} state_t;

endpackage

/* sv/ccs_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_in_if
// Input channel: one set element per transfer, the final one marked.
// ----------------------------------------------------------------------------
interface ccs_in_if;
	logic                             valid;
	logic                             ready;
	logic signed [ccs_pkg::DATA_W-1:0] value;
	logic                             last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

/* sv/ccs_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_out_if
// Output channel: one sorted element per transfer.
// ----------------------------------------------------------------------------
interface ccs_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [ccs_pkg::DATA_W-1:0] sorted_value;
	logic                             final_res;
	logic                             overflow;

	modport source (output valid, output sorted_value, output final_res, output overflow,
		input ready);
	modport sink   (input valid, input sorted_value, input final_res, input overflow,
		output ready);
endinterface

/* sv/ccs_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_cell
// Compare-exchange cell: keeps the smaller of its held and arriving values and
// passes the larger one to its right neighbor, or shifts left while draining.
// ----------------------------------------------------------------------------
module ccs_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  ccs_pkg::link_t carry_in,
	input  ccs_pkg::link_t next_in,
	input  logic           shift,
	output ccs_pkg::link_t carry_out,
	output ccs_pkg::link_t stored
);

	ccs_pkg::link_t stored_q;
	ccs_pkg::link_t carry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q.valid <= 1'b0;
			carry_q.valid  <= 1'b0;
		end else if (shift) begin
			stored_q      <= next_in;
			carry_q.valid <= 1'b0;
		end else if (carry_in.valid) begin
			// An empty cell takes the value; its own empty content goes on as an empty carry.
			if (!stored_q.valid || (carry_in.value < stored_q.value)) begin
				stored_q <= carry_in;
				carry_q  <= stored_q;
			end else begin
				carry_q <= carry_in;
			end
		end else begin
			carry_q.valid <= 1'b0;
		end
	end

	assign carry_out = carry_q;
	assign stored    = stored_q;

endmodule

/* sv/cocktail_shaker_sorter_unit.sv */
`timescale 1ns / 1ps
// Output: after the marked transfer the chain settles, then the first result is offered;
// results leave at one per cycle while the sink is ready.
// Throughput: one element is taken per cycle while loading; a new set is taken only after
// the final result of the previous one has gone out, as the cell chain holds one set.
// Reset: arst_n clears the chain's valid bits, the element count and the overflow flag.
// ----------------------------------------------------------------------------
// cocktail_shaker_sorter_unit
// Sorts a set of signed integers in ascending order in a chain of
// compare-exchange cells and streams the set out from the head of the chain.
// ----------------------------------------------------------------------------
module cocktail_shaker_sorter_unit #(
	parameter int unsigned DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	ccs_in_if.sink    items,
	ccs_out_if.source results
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	ccs_pkg::state_t state_q;
	ccs_pkg::state_t state_next;

	logic [CNT_W-1:0] count_q;
	logic             overflow_q;

	ccs_pkg::link_t carry_w  [DEPTH+1];
	ccs_pkg::link_t stored_w [DEPTH+1];
	logic [DEPTH-1:0] carry_vec;
	logic             carry_any;

	logic in_xfer;
	logic out_xfer;
	logic room;
	logic shift;

	assign in_xfer  = items.valid && items.ready;
	assign out_xfer = results.valid && results.ready;
	assign room     = (count_q < CNT_W'(DEPTH));

	// A dropped element never enters the chain.
	assign carry_w[0].valid  = in_xfer && room;
	assign carry_w[0].value  = items.value;
	assign stored_w[DEPTH]   = '{valid: 1'b0, value: '0};

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			ccs_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.carry_in  (carry_w[gi]),
				.next_in   (stored_w[gi+1]),
				.shift     (shift),
				.carry_out (carry_w[gi+1]),
				.stored    (stored_w[gi])
			);
			assign carry_vec[gi] = carry_w[gi+1].valid;
		end
	endgenerate

	assign carry_any = |carry_vec;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ccs_pkg::ST_LOAD: begin
				if (in_xfer && items.last) state_next = ccs_pkg::ST_SETTLE;
			end
			ccs_pkg::ST_SETTLE: begin
				if (!carry_any) state_next = ccs_pkg::ST_DRAIN;
			end
			ccs_pkg::ST_DRAIN: begin
				if (out_xfer && results.final_res) state_next = ccs_pkg::ST_LOAD;
			end
			default: state_next = ccs_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		items.ready   = 1'b0;
		results.valid = 1'b0;
		case (state_q)
			ccs_pkg::ST_LOAD:   items.ready   = 1'b1;
			ccs_pkg::ST_SETTLE: items.ready   = 1'b0;
			ccs_pkg::ST_DRAIN:  results.valid = stored_w[0].valid;
			default: begin
				items.ready   = 1'b0;
				results.valid = 1'b0;
			end
		endcase
	end

	assign shift                = out_xfer;
	assign results.sorted_value = stored_w[0].value;
	assign results.final_res    = !stored_w[1].valid;
	assign results.overflow     = overflow_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ccs_pkg::ST_LOAD;
			count_q    <= '0;
			overflow_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (out_xfer && results.final_res) begin
				count_q    <= '0;
				overflow_q <= 1'b0;
			end else if (in_xfer) begin
				if (room) count_q <= count_q + CNT_W'(1);
				else      overflow_q <= 1'b1;
			end
		end
	end

	// The chain holds at most DEPTH elements, so nothing ever falls off its end.
	a_no_spill: assert property (@(posedge clk) disable iff (!arst_n)
		!carry_w[DEPTH].valid)
		else $error("element carried past the last cell");

	a_drain_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ccs_pkg::ST_DRAIN) |-> !carry_any)
		else $error("drain started while the chain was still settling");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("element count above store depth");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && results.final_res) |=> (state_q == ccs_pkg::ST_LOAD) && (count_q == '0)
			&& !stored_w[0].valid)
		else $error("set not cleared after its final result");

endmodule

/* dv/tb_cocktail_shaker_sorter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cocktail_shaker_sorter_unit
// Sends sets of signed integers to the sorter and checks each sorted element,
// its final mark and its overflow flag against a local shaker-sort predictor.
// The run covers directed sets for the extremes, a full and an overfull store,
// back-to-back sets, and random sets with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_cocktail_shaker_sorter_unit;

	localparam int unsigned DEPTH          = 64;
	localparam int unsigned RANDOM_ITEMS   = 24;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	typedef logic signed [ccs_pkg::DATA_W-1:0] elem_t;

	localparam elem_t VAL_MAX = elem_t'(32'h7FFF_FFFF);
	localparam elem_t VAL_MIN = elem_t'(32'h8000_0000);

	typedef struct packed {
		elem_t sorted_value;
		logic  final_res;
		logic  overflow;
	} sorted_result_t;

	typedef enum int {
		FILL_WIDE,
		FILL_NARROW,
		FILL_EDGES,
		FILL_RISING,
		FILL_FALLING
	} fill_t;

	logic clk = 1'b0;
	logic arst_n;

	ccs_in_if  in_ch();
	ccs_out_if out_ch();

	cocktail_shaker_sorter_unit #(
		.DEPTH(DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (in_ch),
		.results(out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: the set collected so far and the sorted results owed.
	elem_t          set_store[$];
	bit             set_dropped;
	int unsigned    set_length;
	sorted_result_t pending_results[$];

	int unsigned failures        = 0;
	int unsigned items_sent      = 0;
	int unsigned sets_sent       = 0;
	int unsigned overflow_sets   = 0;
	int unsigned largest_set     = 0;
	int unsigned results_checked = 0;

	bit          sender_gaps = 1'b1;
	bit          sink_stalls = 1'b1;
	int unsigned ready_left  = 0;
	int unsigned stall_left  = 0;
	int unsigned idle_cycles = 0;

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Alternating forward and backward bubble passes; the forward pass trims the
	// upper bound, the backward pass the lower one.
	function automatic void shake_sort(ref elem_t vals[$]);
		int    lo;
		int    hi;
		int    i;
		bit    swapped;
		elem_t t;
		lo = 0;
		hi = vals.size() - 1;
		while (lo < hi) begin
			swapped = 1'b0;
			for (i = lo; i < hi; i++) begin
				if (vals[i] > vals[i+1]) begin
					t = vals[i]; vals[i] = vals[i+1]; vals[i+1] = t;
					swapped = 1'b1;
				end
			end
			if (!swapped)
				break;
			hi--;
			for (i = hi; i > lo; i--) begin
				if (vals[i-1] > vals[i]) begin
					t = vals[i-1]; vals[i-1] = vals[i]; vals[i] = t;
				end
			end
			lo++;
		end
	endfunction

	function automatic void record_element(elem_t value, logic last);
		elem_t          sorted[$];
		sorted_result_t r;
		set_length++;
		if (set_store.size() < DEPTH)
			set_store.push_back(value);
		else
			set_dropped = 1'b1;
		if (last) begin
			sorted = set_store;
			shake_sort(sorted);
			foreach (sorted[k]) begin
				r.sorted_value = sorted[k];
				r.final_res    = (k == sorted.size() - 1);
				r.overflow     = set_dropped;
				pending_results.push_back(r);
			end
			sets_sent++;
			if (set_dropped)
				overflow_sets++;
			if (set_length > largest_set)
				largest_set = set_length;
			set_store.delete();
			set_dropped = 1'b0;
			set_length  = 0;
		end
	endfunction

	function automatic void build_set(int unsigned n, fill_t fill, output elem_t vals[$]);
		elem_t v;
		elem_t step;
		vals.delete();
		v    = $urandom;
		step = $urandom_range(0, 3);
		for (int unsigned i = 0; i < n; i++) begin
			case (fill)
				FILL_WIDE: begin
					v = $urandom;
				end
				FILL_NARROW: begin
					v = $urandom_range(0, 16);
					v = v - 8;
				end
				FILL_EDGES: begin
					case ($urandom_range(0, 6))
						0: v = VAL_MIN;
						1: v = VAL_MIN + 1;
						2: v = -1;
						3: v = 0;
						4: v = 1;
						5: v = VAL_MAX - 1;
						default: v = VAL_MAX;
					endcase
				end
				FILL_RISING: begin
					v = v + step;
				end
				default: begin
					v = v - step;
				end
			endcase
			vals.push_back(v);
		end
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_element(input elem_t value, input logic last);
		int unsigned gap;
		gap = sender_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.value <= value;
		in_ch.last  <= last;
		do @(posedge clk); while (!in_ch.ready);
		record_element(value, last);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_set(input elem_t vals[$]);
		foreach (vals[i])
			send_element(vals[i], i == vals.size() - 1);
	endtask

	// Holds off the sender until every owed result is out, then lets the block
	// run for longer than its settle time.
	task automatic wait_results_out();
		in_ch.valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (DEPTH + 8) @(negedge clk);
	endtask

	task automatic test_single_elements();
		send_set('{VAL_MIN});
		send_set('{VAL_MAX});
		send_set('{elem_t'(0)});
		wait_results_out();
	endtask

	task automatic test_extreme_values();
		send_set('{VAL_MAX, VAL_MIN, elem_t'(-1), elem_t'(0), elem_t'(1), VAL_MIN, VAL_MAX});
		wait_results_out();
	endtask

	task automatic test_orderings();
		send_set('{elem_t'(2), elem_t'(1)});
		send_set('{elem_t'(5), elem_t'(5), elem_t'(5)});
		send_set('{elem_t'(-3), elem_t'(-2), elem_t'(-1), elem_t'(0)});
		wait_results_out();
	endtask

	// A set that exactly fills the store, then one that overruns it so that the
	// marked element itself is dropped.
	task automatic test_store_full();
		elem_t vals[$];
		build_set(DEPTH, FILL_FALLING, vals);
		send_set(vals);
		build_set(DEPTH + 3, FILL_WIDE, vals);
		send_set(vals);
		wait_results_out();
	endtask

	task automatic test_back_to_back();
		elem_t vals[$];
		sender_gaps = 1'b0;
		sink_stalls = 1'b0;
		repeat (3) begin
			build_set($urandom_range(1, 6), fill_t'($urandom_range(0, 4)), vals);
			send_set(vals);
		end
		wait_results_out();
		sender_gaps = 1'b1;
		sink_stalls = 1'b1;
	endtask

	task automatic test_random_sets();
		elem_t       vals[$];
		int unsigned n;
		int unsigned r;
		int unsigned sent;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				n = $urandom_range(1, 8);
			else if (r < 92)
				n = $urandom_range(9, 24);
			else if (r < 97)
				n = $urandom_range(25, DEPTH);
			else
				n = $urandom_range(DEPTH + 1, DEPTH + 4);
			build_set(n, fill_t'($urandom_range(0, 4)), vals);
			send_set(vals);
			sent += n;
			if ($urandom_range(0, 9) == 0)
				wait_results_out();
		end
		wait_results_out();
	endtask

	// Output side: bursts of ready with stalls of random length between them.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (ready_left > 0) begin
			out_ch.ready <= 1'b1;
			ready_left--;
		end else if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			out_ch.ready <= 1'b1;
			ready_left = $urandom_range(0, 23);
			stall_left = sink_stalls ? pick_gap() : 0;
		end
	end

	always @(posedge clk) begin
		sorted_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				$display("%0t: result with none owed: sorted_value=%0d final_res=%0b overflow=%0b",
					$time, out_ch.sorted_value, out_ch.final_res, out_ch.overflow);
				failures++;
			end else begin
				want = pending_results.pop_front();
				if (out_ch.sorted_value !== want.sorted_value) begin
					$display("%0t: sorted_value expected %0d, actual %0d",
						$time, want.sorted_value, out_ch.sorted_value);
					failures++;
				end
				if (out_ch.final_res !== want.final_res) begin
					$display("%0t: final_res expected %0b, actual %0b",
						$time, want.final_res, out_ch.final_res);
					failures++;
				end
				if (out_ch.overflow !== want.overflow) begin
					$display("%0t: overflow expected %0b, actual %0b",
						$time, want.overflow, out_ch.overflow);
					failures++;
				end
			end
		end
	end

	// Ends the run when no transfer happens on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results still owed",
				$time, idle_cycles, pending_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		in_ch.valid  = 1'b0;
		in_ch.value  = '0;
		in_ch.last   = 1'b0;
		set_dropped  = 1'b0;
		set_length   = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_single_elements();
		test_extreme_values();
		test_orderings();
		test_store_full();
		test_back_to_back();
		test_random_sets();

		$display("Sent %0d elements in %0d sets (largest %0d, %0d past the store depth).",
			items_sent, sets_sent, largest_set, overflow_sets);
		$display("Checked %0d sorted results, %0d mismatches.", results_checked, failures);
		if (failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
